@@ design/blur_pkg.sv @@
// ----------------------------------------------------------------------------
// blur_pkg: shared types and constants of the bounded list undo/redo unit
// Sizes of the list ring and history ring, opcode codes and the layout of
// one history record.
// ----------------------------------------------------------------------------
package blur_pkg;

  // Ring depth of both the list and the history; ring pointers wrap
  // naturally, so the depth is a power of two.
  localparam int MAX_HISTORY = 64;
  localparam int WORD_BITS   = 32;
  localparam int PTR_W       = $clog2(MAX_HISTORY);
  localparam int CNT_W       = PTR_W + 1;

  // Fixed field widths of the item ports
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // Width used to compare a slot against a length
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_REPLACE = 3'd1,
    OP_UNDO    = 3'd2,
    OP_REDO    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  // One change record of the history ring
  typedef struct packed {
    logic                 is_replace;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_BITS-1:0] prior;
    logic [WORD_BITS-1:0] after;
    logic                 ev_valid;
    logic [WORD_BITS-1:0] ev_word;
  } hist_rec_t;

  localparam int HREC_W = $bits(hist_rec_t);

endpackage

@@ design/bounded_list_undo_redo_unit.sv @@
// Each item steps through the states fetch, execute, readback read and result
// (FETCH, EXEC, READ, DONE). The unit takes no new item while busy; a new item
// may be started in the cycle the result is shown. The steps are set by the
// registered reads of the list and history RAMs, read once before and once
// after the update. Reset empties the list and history at once; the RAM
// contents are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
// bounded_list_undo_redo_unit: bounded word list with undo/redo history
// Keeps a ring of list words and a ring of change records in two RAMs and
// runs add, replace, undo, redo and clear as a read-modify-write sequence.
// ----------------------------------------------------------------------------
module bounded_list_undo_redo_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [blur_pkg::OP_W-1:0]      in_opcode,
  input  logic [blur_pkg::SLOT_W-1:0]    in_slot,
  input  logic [blur_pkg::WORD_BITS-1:0] in_word,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [blur_pkg::COUNT_W-1:0]   out_item_count,
  output logic                           out_can_undo,
  output logic                           out_can_redo,
  output logic [blur_pkg::WORD_BITS-1:0] out_read_word
);
  import blur_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state_r;

  // Latched item
  logic [OP_W-1:0]      op_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [WORD_BITS-1:0] word_r;

  // List and history pointers
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [PTR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] undo_r, undo_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             ok_r, ok_nxt;
  logic             rb_hit_r;

  // RAM ports
  logic                 list_we;
  logic [PTR_W-1:0]     list_waddr, list_raddr;
  logic [WORD_BITS-1:0] list_wdata, list_rd;
  logic                 hist_we;
  logic [PTR_W-1:0]     hist_waddr, hist_raddr;
  hist_rec_t            hist_wdata, hist_rd;
  logic [HREC_W-1:0]    hist_rd_bits;

  logic             accept;
  logic [PTR_W-1:0] slot_ptr;

  assign busy     = (state_r != ST_IDLE) && (state_r != ST_DONE);
  assign accept   = start && !busy;
  assign slot_ptr = head_r + PTR_W'(slot_r);
  assign hist_rd  = hist_rec_t'(hist_rd_bits);

  blur_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_HISTORY)) u_list_ram (
    .clk   (clk),
    .we    (list_we && (state_r == ST_EXEC)),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rd)
  );

  blur_ram #(.WIDTH(HREC_W), .DEPTH(MAX_HISTORY)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we && (state_r == ST_EXEC)),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rd_bits)
  );

  // Select read addresses: add fetches the front word, others the slot word
  always_comb begin
    if ((state_r == ST_FETCH) && (op_r == OP_ADD)) begin
      list_raddr = head_r;
    end else begin
      list_raddr = slot_ptr;
    end
    if (op_r == OP_UNDO) begin
      hist_raddr = base_r + PTR_W'(undo_r - CNT_W'(1));
    end else begin
      hist_raddr = base_r + PTR_W'(undo_r);
    end
  end

  // Execute one operation on the fetched data
  always_comb begin
    logic [PTR_W-1:0] h;
    logic [CNT_W-1:0] l;
    logic [PTR_W-1:0] rec_base;
    logic [CNT_W-1:0] rec_undo;
    logic             slot_ok;
    logic             rec_slot_ok;

    head_nxt   = head_r;
    len_nxt    = len_r;
    base_nxt   = base_r;
    undo_nxt   = undo_r;
    total_nxt  = total_r;
    ok_nxt     = 1'b0;
    list_we    = 1'b0;
    list_waddr = slot_ptr;
    list_wdata = word_r;
    hist_we    = 1'b0;
    hist_wdata = '0;
    h          = head_r;
    l          = len_r;

    // Record slot of a new change: drop the oldest when the history is full
    if (undo_r == CNT_W'(MAX_HISTORY)) begin
      rec_base = base_r + PTR_W'(1);
      rec_undo = undo_r - CNT_W'(1);
    end else begin
      rec_base = base_r;
      rec_undo = undo_r;
    end
    hist_waddr  = rec_base + PTR_W'(rec_undo);
    slot_ok     = CMP_W'(slot_r) < CMP_W'(len_r);
    rec_slot_ok = CMP_W'(hist_rd.slot) < CMP_W'(len_r);

    case (op_r)
      OP_ADD: begin
        hist_wdata.ev_valid = 1'b0;
        hist_wdata.ev_word  = list_rd;
        if (len_r == CNT_W'(MAX_HISTORY)) begin
          hist_wdata.ev_valid = 1'b1;
          h = head_r + PTR_W'(1);
          l = len_r - CNT_W'(1);
        end
        list_we              = 1'b1;
        list_waddr           = h + PTR_W'(l);
        list_wdata           = word_r;
        hist_we              = 1'b1;
        hist_wdata.is_replace = 1'b0;
        hist_wdata.slot      = SLOT_W'(l);
        hist_wdata.after     = word_r;
        head_nxt             = h;
        len_nxt              = l + CNT_W'(1);
        base_nxt             = rec_base;
        undo_nxt             = rec_undo + CNT_W'(1);
        total_nxt            = rec_undo + CNT_W'(1);
        ok_nxt               = 1'b1;
      end
      OP_REPLACE: begin
        if (slot_ok) begin
          list_we               = 1'b1;
          list_waddr            = slot_ptr;
          list_wdata            = word_r;
          hist_we               = 1'b1;
          hist_wdata.is_replace = 1'b1;
          hist_wdata.slot       = slot_r;
          hist_wdata.prior      = list_rd;
          hist_wdata.after      = word_r;
          base_nxt              = rec_base;
          undo_nxt              = rec_undo + CNT_W'(1);
          total_nxt             = rec_undo + CNT_W'(1);
          ok_nxt                = 1'b1;
        end
      end
      OP_UNDO: begin
        if (undo_r != '0) begin
          if (!hist_rd.is_replace) begin
            // Remove the added word; put an evicted word back at the front
            if (len_r != '0) begin
              ok_nxt   = 1'b1;
              len_nxt  = len_r - CNT_W'(1);
              if (hist_rd.ev_valid) begin
                head_nxt   = head_r - PTR_W'(1);
                len_nxt    = len_r;
                list_we    = 1'b1;
                list_waddr = head_r - PTR_W'(1);
                list_wdata = hist_rd.ev_word;
              end
            end
          end else if (rec_slot_ok) begin
            ok_nxt     = 1'b1;
            list_we    = 1'b1;
            list_waddr = head_r + PTR_W'(hist_rd.slot);
            list_wdata = hist_rd.prior;
          end
          if (ok_nxt) begin
            undo_nxt = undo_r - CNT_W'(1);
          end
        end
      end
      OP_REDO: begin
        if (undo_r < total_r) begin
          if (!hist_rd.is_replace) begin
            // Drop the front word if the add had evicted one, then append
            if (hist_rd.ev_valid && (l != '0)) begin
              h = h + PTR_W'(1);
              l = l - CNT_W'(1);
            end
            if (l == CNT_W'(MAX_HISTORY)) begin
              h = h + PTR_W'(1);
              l = l - CNT_W'(1);
            end
            ok_nxt     = 1'b1;
            list_we    = 1'b1;
            list_waddr = h + PTR_W'(l);
            list_wdata = hist_rd.after;
            head_nxt   = h;
            len_nxt    = l + CNT_W'(1);
          end else if (rec_slot_ok) begin
            ok_nxt     = 1'b1;
            list_we    = 1'b1;
            list_waddr = head_r + PTR_W'(hist_rd.slot);
            list_wdata = hist_rd.after;
          end
          if (ok_nxt) begin
            undo_nxt = undo_r + CNT_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        len_nxt   = '0;
        base_nxt  = '0;
        undo_nxt  = '0;
        total_nxt = '0;
        ok_nxt    = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Sequence the item and hold the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      len_r     <= '0;
      base_r    <= '0;
      undo_r    <= '0;
      total_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            op_r    <= in_opcode;
            slot_r  <= in_slot;
            word_r  <= in_word;
            state_r <= ST_FETCH;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          head_r  <= head_nxt;
          len_r   <= len_nxt;
          base_r  <= base_nxt;
          undo_r  <= undo_nxt;
          total_r <= total_nxt;
          ok_r    <= ok_nxt;
          state_r <= ST_READ;
        end
        ST_READ: begin
          out_valid      <= 1'b1;
          out_ok         <= ok_r;
          out_item_count <= COUNT_W'(len_r);
          out_can_undo   <= (undo_r != '0);
          out_can_redo   <= (total_r > undo_r);
          rb_hit_r       <= CMP_W'(slot_r) < CMP_W'(len_r);
          state_r        <= ST_DONE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Show the readback word only for a slot inside the list
  assign out_read_word = rb_hit_r ? list_rd : '0;

  // Result strobe is a single-cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("unit not busy after accepting an item");

  // Undo depth never exceeds the recorded history
  a_undo_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    (undo_r <= total_r) && (total_r <= CNT_W'(MAX_HISTORY)))
    else $error("history counters out of order");

  // Reported length stays within the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_count <= COUNT_W'(MAX_HISTORY)))
    else $error("list length beyond ring depth");

endmodule

@@ design/blur_ram.sv @@
// ----------------------------------------------------------------------------
// blur_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module blur_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded list undo/redo unit
// Feeds add, replace, undo, redo, clear and unknown commands through the
// start/busy handshake with random gaps, tracks the list and its change
// history in a shadow copy, and checks every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import blur_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 1830;
  localparam int SETTLE_CYCLES = 8;
  localparam int FIRST_BAD_OP = int'(OP_CLEAR) + 1;
  localparam int LAST_BAD_OP  = (1 << OP_W) - 1;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_UNWIND, MODE_REPLAY} mix_mode_t;

  typedef struct {
    logic [OP_W-1:0]      opcode;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_BITS-1:0] word;
    bit                   drain;
  } command_t;

  typedef struct packed {
    logic                 ok;
    logic [COUNT_W-1:0]   count;
    logic                 can_undo;
    logic                 can_redo;
    logic [WORD_BITS-1:0] rword;
  } outcome_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [SLOT_W-1:0]    in_slot   = '0;
  logic [WORD_BITS-1:0] in_word   = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_ok;
  logic [COUNT_W-1:0]   out_item_count;
  logic                 out_can_undo;
  logic                 out_can_redo;
  logic [WORD_BITS-1:0] out_read_word;

  command_t pending_cmds[$];
  outcome_t expected_outcomes[$];
  int       items_accepted = 0;
  int       results_seen   = 0;
  int       error_count    = 0;
  int       cycle_count    = 0;
  int       idle_left      = 0;
  bit       idle_on        = 1'b0;

  // Shadow copy of the list ring and the change journal
  logic [WORD_BITS-1:0] shadow_words [MAX_HISTORY];
  logic [PTR_W-1:0]     shadow_head  = '0;
  logic [CNT_W-1:0]     shadow_len   = '0;
  hist_rec_t            journal      [MAX_HISTORY];
  logic [PTR_W-1:0]     journal_base = '0;
  logic [CNT_W-1:0]     journal_undo = '0;
  logic [CNT_W-1:0]     journal_top  = '0;

  bounded_list_undo_redo_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_slot        (in_slot),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_item_count (out_item_count),
    .out_can_undo   (out_can_undo),
    .out_can_redo   (out_can_redo),
    .out_read_word  (out_read_word)
  );

  // Drop the word at the front of the list, if any
  function automatic void drop_oldest_word();
    if (shadow_len != 0) begin
      shadow_head = shadow_head + 1'b1;
      shadow_len  = shadow_len - 1'b1;
    end
  endfunction

  // Append a word, evicting the front word when the list is full
  function automatic void append_word(logic [WORD_BITS-1:0] w);
    logic [PTR_W-1:0] pos;
    if (shadow_len >= MAX_HISTORY) drop_oldest_word();
    pos = shadow_head + shadow_len[PTR_W-1:0];
    shadow_words[pos] = w;
    shadow_len = shadow_len + 1'b1;
  endfunction

  // Record a change, discarding redo entries and the oldest change if full
  function automatic void log_change(hist_rec_t rec);
    logic [PTR_W-1:0] pos;
    if (journal_undo >= MAX_HISTORY) begin
      journal_base = journal_base + 1'b1;
      journal_undo = journal_undo - 1'b1;
    end
    pos = journal_base + journal_undo[PTR_W-1:0];
    journal[pos] = rec;
    journal_undo = journal_undo + 1'b1;
    journal_top  = journal_undo;
  endfunction

  // Apply one command to the shadow state and return the result it yields
  function automatic outcome_t apply_command(logic [OP_W-1:0] op,
                                             logic [SLOT_W-1:0] slot,
                                             logic [WORD_BITS-1:0] word);
    hist_rec_t        rec;
    logic [PTR_W-1:0] pos;
    logic             ok;
    outcome_t         res;
    ok  = 1'b1;
    rec = '0;
    case (op)
      OP_ADD: begin
        if (shadow_len >= MAX_HISTORY) begin
          rec.ev_valid = 1'b1;
          rec.ev_word  = shadow_words[shadow_head];
          drop_oldest_word();
        end
        append_word(word);
        rec.slot  = SLOT_W'(shadow_len - 1'b1);
        rec.after = word;
        log_change(rec);
      end
      OP_REPLACE: begin
        if (slot >= shadow_len) begin
          ok = 1'b0;
        end else begin
          pos = shadow_head + slot;
          rec.is_replace = 1'b1;
          rec.slot       = slot;
          rec.prior      = shadow_words[pos];
          rec.after      = word;
          log_change(rec);
          shadow_words[pos] = word;
        end
      end
      OP_UNDO: begin
        if (journal_undo == 0) begin
          ok = 1'b0;
        end else begin
          pos = journal_base + journal_undo[PTR_W-1:0] - 1'b1;
          rec = journal[pos];
          if (!rec.is_replace) begin
            if (shadow_len == 0) begin
              ok = 1'b0;
            end else begin
              shadow_len = shadow_len - 1'b1;
              // put the evicted word back at the front
              if (rec.ev_valid) begin
                shadow_head = shadow_head - 1'b1;
                shadow_words[shadow_head] = rec.ev_word;
                shadow_len = shadow_len + 1'b1;
              end
            end
          end else if (rec.slot >= shadow_len) begin
            ok = 1'b0;
          end else begin
            pos = shadow_head + rec.slot;
            shadow_words[pos] = rec.prior;
          end
          if (ok) journal_undo = journal_undo - 1'b1;
        end
      end
      OP_REDO: begin
        if (journal_undo >= journal_top) begin
          ok = 1'b0;
        end else begin
          pos = journal_base + journal_undo[PTR_W-1:0];
          rec = journal[pos];
          if (!rec.is_replace) begin
            if (rec.ev_valid) drop_oldest_word();
            append_word(rec.after);
          end else if (rec.slot >= shadow_len) begin
            ok = 1'b0;
          end else begin
            pos = shadow_head + rec.slot;
            shadow_words[pos] = rec.after;
          end
          if (ok) journal_undo = journal_undo + 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_head  = '0;
        shadow_len   = '0;
        journal_base = '0;
        journal_undo = '0;
        journal_top  = '0;
      end
      default: ok = 1'b0;
    endcase
    res.ok       = ok;
    res.count    = COUNT_W'(shadow_len);
    res.can_undo = (journal_undo != 0);
    res.can_redo = (journal_top > journal_undo);
    pos          = shadow_head + slot;
    res.rword    = (slot < shadow_len) ? shadow_words[pos] : '0;
    return res;
  endfunction

  task automatic queue_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [WORD_BITS-1:0] word, bit drain);
    command_t c;
    c.opcode = op;
    c.slot   = slot;
    c.word   = word;
    c.drain  = drain;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Clock, reset and cycle counter
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Driver: present queued items, predict on acceptance, insert random gaps
  always @(posedge clk) begin : drive_proc
    logic     fire;
    command_t nxt;
    fire = start && !busy;
    if (!rst_n) begin
      start     <= 1'b0;
      idle_left  = 0;
    end else begin
      if (fire) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 apply_command(in_opcode, in_slot, in_word));
        items_accepted <= items_accepted + 1;
        if (items_accepted % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
        idle_left = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (!start || fire) begin
        if (idle_left != 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain ||
                      (!fire && items_accepted == results_seen))) begin
          nxt = pending_cmds.pop_front();
          start     <= 1'b1;
          in_opcode <= nxt.opcode;
          in_slot   <= nxt.slot;
          in_word   <= nxt.word;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_proc
    outcome_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_outcomes.size() == 0) begin
        $error("result with no prediction pending");
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_ok !== want.ok) begin
          $error("out_ok mismatch: expected %0d, actual %0d", want.ok, out_ok);
          error_count++;
        end
        if (out_item_count !== want.count) begin
          $error("out_item_count mismatch: expected %0d, actual %0d",
                 want.count, out_item_count);
          error_count++;
        end
        if (out_can_undo !== want.can_undo) begin
          $error("out_can_undo mismatch: expected %0d, actual %0d",
                 want.can_undo, out_can_undo);
          error_count++;
        end
        if (out_can_redo !== want.can_redo) begin
          $error("out_can_redo mismatch: expected %0d, actual %0d",
                 want.can_redo, out_can_redo);
          error_count++;
        end
        if (out_read_word !== want.rword) begin
          $error("out_read_word mismatch: expected %h, actual %h",
                 want.rword, out_read_word);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed corner cases, then random command mixes
  initial begin : stimulus
    mix_mode_t            mode;
    int                   block_left;
    int                   roll;
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_BITS-1:0] word;

    for (int i = 0; i < MAX_HISTORY; i++) begin
      shadow_words[i] = '0;
      journal[i]      = '0;
    end

    // refusals on an empty unit
    queue_command(OP_UNDO, '0, '0, 1'b0);
    queue_command(OP_REDO, '0, '0, 1'b0);
    queue_command(OP_REPLACE, '0, 32'h1234_5678, 1'b0);
    queue_command(OP_W'(FIRST_BAD_OP), 6'd1, 32'h0000_0001, 1'b0);
    queue_command(OP_W'(FIRST_BAD_OP + 1), 6'd2, 32'h8000_0000, 1'b0);
    queue_command(OP_W'(LAST_BAD_OP), '1, '1, 1'b0);
    // word extremes, readback out of range
    queue_command(OP_ADD, '0, '1, 1'b0);
    queue_command(OP_ADD, 6'd1, '0, 1'b0);
    queue_command(OP_ADD, '1, 32'hA5A5_A5A5, 1'b0);
    queue_command(OP_REPLACE, 6'd1, 32'h5A5A_5A5A, 1'b0);
    queue_command(OP_REPLACE, '1, 32'hFFFF_0000, 1'b0);
    // undo and redo of a replace and of an add
    queue_command(OP_UNDO, 6'd1, '0, 1'b0);
    queue_command(OP_REDO, 6'd1, '0, 1'b0);
    queue_command(OP_UNDO, 6'd2, '0, 1'b0);
    queue_command(OP_UNDO, 6'd2, '0, 1'b0);
    queue_command(OP_REDO, 6'd2, '0, 1'b0);
    // a new change drops the redo entry
    queue_command(OP_ADD, 6'd3, 32'h1234_5678, 1'b0);
    queue_command(OP_REDO, 6'd3, '0, 1'b0);
    queue_command(OP_REPLACE, 6'd0, 32'h0F0F_0F0F, 1'b0);
    // clear wipes list and history
    queue_command(OP_CLEAR, '0, '0, 1'b0);
    queue_command(OP_UNDO, '0, '0, 1'b0);
    queue_command(OP_REDO, '0, '0, 1'b0);

    // start with a long fill so eviction shows up early
    mode       = MODE_FILL;
    block_left = 150;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (block_left == 0) begin
        mode       = mix_mode_t'($urandom_range(0, 3));
        block_left = $urandom_range(40, 120);
      end
      block_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:
          op = (roll < 85) ? OP_ADD : (roll < 95) ? OP_REPLACE : OP_UNDO;
        MODE_UNWIND:
          op = (roll < 70) ? OP_UNDO : (roll < 85) ? OP_REDO :
               (roll < 95) ? OP_REPLACE : OP_ADD;
        MODE_REPLAY:
          op = (roll < 60) ? OP_REDO : (roll < 80) ? OP_UNDO :
               (roll < 90) ? OP_REPLACE : OP_ADD;
        default:
          op = (roll < 30) ? OP_ADD : (roll < 55) ? OP_REPLACE :
               (roll < 73) ? OP_UNDO : (roll < 90) ? OP_REDO :
               (roll < 93) ? OP_CLEAR : (roll < 96) ?
               OP_W'($urandom_range(FIRST_BAD_OP, LAST_BAD_OP)) : OP_ADD;
      endcase
      slot = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 63))
                                  : SLOT_W'($urandom_range(0, 7));
      roll = $urandom_range(0, 15);
      word = (roll == 0) ? '0 : (roll == 1) ? '1 : WORD_BITS'($urandom);
      queue_command(op, slot, word, (n % 150 == 0));
    end

    // wait for the last item and its result, then let the unit settle
    while (pending_cmds.size() != 0 || start || items_accepted != results_seen)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_outcomes.size() != 0) begin
      $error("%0d predicted results never arrived", expected_outcomes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
